// File: src/gpca_pkg.sv
// Package for the gated pulse count accumulator.
// Holds the word types, configuration codes and window conversion constants.
// No dependencies.
`timescale 1ns / 1ps

package gpca_pkg;

	// Field widths
	localparam int HW_COUNT_WIDTH = 16;
	localparam int TOTAL_W        = 32;
	localparam int FOLD_W         = 15;
	localparam int WINDOW_W       = 15;
	localparam int DEBOUNCE_W     = 24;
	localparam int CFG_DATA_W     = 24;
	localparam int CFG_IDX_W      = 2;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_HIGH    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_US    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FOLD_THRESHOLD = 2'd2;

	// Reset values of the registers
	localparam logic                RST_ACTIVE_HIGH    = 1'b1;
	localparam logic [FOLD_W-1:0]   RST_FOLD_THRESHOLD = 15'd16384;

	// ceil(us / 1000) = ((us + 999) * RECIP_1000) >> RECIP_SHIFT, exact for sums below 2^25
	localparam int                  ROUND_W     = DEBOUNCE_W + 1;
	localparam logic [ROUND_W-1:0]  ROUND_UP    = 25'd999;
	localparam int                  RECIP_W     = 26;
	localparam logic [RECIP_W-1:0]  RECIP_1000  = 26'd34359739;
	localparam int                  RECIP_SHIFT = 35;

	// Input word: one sample
	typedef struct packed {
		logic [31:0]                       now_ms;
		logic signed [HW_COUNT_WIDTH-1:0]  hw_count;
		logic                              pin_level;
	} sample_t;

	// Output word: one result
	typedef struct packed {
		logic               logical_on;
		logic [TOTAL_W-1:0] accepted_pulses;
		logic [TOTAL_W-1:0] raw_pulses;
		logic [TOTAL_W-1:0] ignored_pulses;
		logic [TOTAL_W-1:0] samples_taken;
		logic [TOTAL_W-1:0] folds_done;
		logic [TOTAL_W-1:0] last_accept_ms;
		logic               clear_request;
	} result_t;

	// Settings as seen by the update logic
	typedef struct packed {
		logic                active_high;
		logic [WINDOW_W-1:0] window_ms;
		logic [FOLD_W-1:0]   fold_threshold;
	} cfg_t;

endpackage

// File: src/gpca_cfg.sv
// Configuration registers of the gated pulse count accumulator.
// Converts the debounce time to whole milliseconds at write time.
// Depends on gpca_pkg.
`timescale 1ns / 1ps

module gpca_cfg (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [gpca_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [gpca_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	output gpca_pkg::cfg_t                       cfg
);

	logic [gpca_pkg::ROUND_W-1:0]                        round_sum;
	logic [gpca_pkg::ROUND_W+gpca_pkg::RECIP_W-1:0]      recip_prod;
	logic [gpca_pkg::WINDOW_W-1:0]                       window_new;
	gpca_pkg::cfg_t                                      cfg_q;

	// Round up to ms with a reciprocal multiply
	always_comb begin
		round_sum  = gpca_pkg::ROUND_W'(cfg_wdata[gpca_pkg::DEBOUNCE_W-1:0])
			+ gpca_pkg::ROUND_UP;
		recip_prod = (gpca_pkg::ROUND_W+gpca_pkg::RECIP_W)'(round_sum)
			* (gpca_pkg::ROUND_W+gpca_pkg::RECIP_W)'(gpca_pkg::RECIP_1000);
		window_new = recip_prod[gpca_pkg::RECIP_SHIFT+gpca_pkg::WINDOW_W-1:gpca_pkg::RECIP_SHIFT];
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_high    <= gpca_pkg::RST_ACTIVE_HIGH;
			cfg_q.window_ms      <= '0;
			cfg_q.fold_threshold <= gpca_pkg::RST_FOLD_THRESHOLD;
		end else if (cfg_we) begin
			unique case (cfg_index)
				gpca_pkg::CFG_ACTIVE_HIGH: begin
					cfg_q.active_high <= cfg_wdata[0];
				end
				gpca_pkg::CFG_DEBOUNCE_US: begin
					cfg_q.window_ms <= window_new;
				end
				gpca_pkg::CFG_FOLD_THRESHOLD: begin
					cfg_q.fold_threshold <= cfg_wdata[gpca_pkg::FOLD_W-1:0];
				end
				default: begin
					// unknown index: write ignored
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/gpca_core.sv
// Update logic and running state of the gated pulse count accumulator.
// Takes one sample per enabled cycle and produces its result word.
// Depends on gpca_pkg.
`timescale 1ns / 1ps

module gpca_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  gpca_pkg::sample_t    sample,
	input  gpca_pkg::cfg_t       cfg,
	output gpca_pkg::result_t    result
);

	localparam int HW = gpca_pkg::HW_COUNT_WIDTH;
	localparam int TW = gpca_pkg::TOTAL_W;

	// Running state
	logic signed [HW-1:0] prev_hw_q;
	logic [TW-1:0]        idle_since_q;
	logic                 armed_q;
	logic [TW-1:0]        acc_q;
	logic [TW-1:0]        raw_q;
	logic [TW-1:0]        ign_q;
	logic [TW-1:0]        smp_q;
	logic [TW-1:0]        fold_q;
	logic [TW-1:0]        acc_time_q;

	// Next-state values
	logic signed [HW:0]   hw_x;
	logic signed [HW:0]   thr_x;
	logic signed [HW:0]   delta;
	logic                 on;
	logic                 fold;
	logic                 pos;
	logic                 win_zero;
	logic [TW-1:0]        d32;
	logic [TW-1:0]        idle_n;
	logic                 armed_n;
	logic [TW-1:0]        acc_n;
	logic [TW-1:0]        raw_n;
	logic [TW-1:0]        ign_n;
	logic [TW-1:0]        acc_time_n;

	// Polarity, fold test and count delta
	always_comb begin
		on       = cfg.active_high ? sample.pin_level : ~sample.pin_level;
		hw_x     = {sample.hw_count[HW-1], sample.hw_count};
		thr_x    = $signed({{(HW+1-gpca_pkg::FOLD_W){1'b0}}, cfg.fold_threshold});
		fold     = (hw_x >= thr_x) || (hw_x <= -thr_x);
		delta    = hw_x - {prev_hw_q[HW-1], prev_hw_q};
		pos      = !delta[HW] && (delta != '0);
		d32      = TW'(delta[HW-1:0]);
		win_zero = (cfg.window_ms == '0);
	end

	// Idle timer, gate and totals
	always_comb begin
		idle_n     = idle_since_q;
		armed_n    = armed_q;
		acc_n      = acc_q;
		raw_n      = raw_q;
		ign_n      = ign_q;
		acc_time_n = acc_time_q;

		if (!on) begin
			if (idle_since_q == '0) begin
				idle_n = sample.now_ms;
			end
			if (win_zero || ((sample.now_ms - idle_n) >= TW'(cfg.window_ms))) begin
				armed_n = 1'b1;
			end
		end else begin
			idle_n = '0;
		end

		if (pos) begin
			raw_n = raw_q + d32;
			priority if (win_zero) begin
				acc_n      = acc_q + d32;
				acc_time_n = sample.now_ms;
			end else if (armed_n) begin
				acc_n      = acc_q + TW'(1);
				acc_time_n = sample.now_ms;
				armed_n    = 1'b0;
				idle_n     = '0;
				ign_n      = ign_q + d32 - TW'(1);
			end else begin
				ign_n = ign_q + d32;
			end
		end
	end

	// State update per sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_hw_q    <= '0;
			idle_since_q <= '0;
			armed_q      <= 1'b0;
			acc_q        <= '0;
			raw_q        <= '0;
			ign_q        <= '0;
			smp_q        <= '0;
			fold_q       <= '0;
			acc_time_q   <= '0;
		end else if (en) begin
			prev_hw_q    <= fold ? '0 : sample.hw_count;
			idle_since_q <= idle_n;
			armed_q      <= armed_n;
			acc_q        <= acc_n;
			raw_q        <= raw_n;
			ign_q        <= ign_n;
			smp_q        <= smp_q + TW'(1);
			fold_q       <= fold_q + TW'(fold);
			acc_time_q   <= acc_time_n;
		end
	end

	// Result word for this sample
	always_comb begin
		result.logical_on      = on;
		result.accepted_pulses = acc_n;
		result.raw_pulses      = raw_n;
		result.ignored_pulses  = ign_n;
		result.samples_taken   = smp_q + TW'(1);
		result.folds_done      = fold_q + TW'(fold);
		result.last_accept_ms  = acc_time_n;
		result.clear_request   = fold;
	end

endmodule

// File: src/gated_pulse_count_accumulator.sv
// Top level of the gated pulse count accumulator.
// Instantiates gpca_cfg and gpca_core; depends on gpca_pkg.
//
// Usage:
//   sample channel (sample_valid / sample_ready / sample) carries one word per
//   reading: timestamp in ms, signed hardware counter value and raw pin level.
//   result channel (result_valid / result_ready / result) returns one word per
//   sample: logical level, running totals, last accept time and clear request.
//   cfg_we / cfg_index / cfg_wdata write the polarity, debounce time (us) and
//   fold threshold; write only while no sample is in flight.
// Flow: an accepted sample sits in the sample register; its result is captured
//   in the result register. Throughput: one sample per cycle while results are
//   taken; the whole update is one pass through the core between the two registers.
// Reset: all totals, the idle timer and the gate clear; polarity resets to
//   active high, debounce to zero and the fold threshold to 16384. No clearing
//   pass is needed, samples are taken right after reset.
// Stall: a held result keeps its word; the sample register still fills, then
//   sample_ready drops until the result is taken.
`timescale 1ns / 1ps

module gated_pulse_count_accumulator (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             sample_valid,
	output logic                             sample_ready,
	input  gpca_pkg::sample_t                sample,
	output logic                             result_valid,
	input  logic                             result_ready,
	output gpca_pkg::result_t                result,
	input  logic                             cfg_we,
	input  logic [gpca_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [gpca_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	gpca_pkg::cfg_t     cfg;
	gpca_pkg::sample_t  sample_s1;
	logic               valid_s1;
	gpca_pkg::result_t  core_res;
	gpca_pkg::result_t  result_s2;
	logic               valid_s2;
	logic               adv_s1;

	// Handshake: stage 1 moves when the result register is free or draining
	assign adv_s1       = valid_s1 && (!valid_s2 || result_ready);
	assign sample_ready = !valid_s1 || adv_s1;

	// Sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_valid && sample_ready) begin
			sample_s1 <= sample;
		end
	end

	gpca_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	gpca_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (core_res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || result_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_s2 <= core_res;
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

// File: src/gpca_checker.sv
// Port-level checker for the gated pulse count accumulator, bound to the top.
// Depends on gpca_pkg and gated_pulse_count_accumulator.
`timescale 1ns / 1ps

module gpca_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               result_valid,
	input  logic               result_ready,
	input  gpca_pkg::result_t  result
);

	logic                          seen_q;
	logic [gpca_pkg::TOTAL_W-1:0]  last_smp_q;
	logic [gpca_pkg::TOTAL_W-1:0]  last_fold_q;
	logic                          out_acc;

	assign out_acc = result_valid && result_ready;

	// Remember the last delivered word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_smp_q  <= '0;
			last_fold_q <= '0;
		end else if (out_acc) begin
			seen_q      <= 1'b1;
			last_smp_q  <= result.samples_taken;
			last_fold_q <= result.folds_done;
		end
	end

	// A stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// Each word is the next sample, none lost or repeated
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_q |->
			result.samples_taken == last_smp_q + gpca_pkg::TOTAL_W'(1))
		else $error("sample count skipped or repeated");

	// Fold count moves exactly with the clear request
	a_fold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && seen_q |->
			result.folds_done == last_fold_q + gpca_pkg::TOTAL_W'(result.clear_request))
		else $error("fold count out of step with clear request");

	// Every raw edge is either accepted or ignored
	a_split: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |->
			result.raw_pulses == result.accepted_pulses + result.ignored_pulses)
		else $error("raw total differs from accepted plus ignored");

endmodule

bind gated_pulse_count_accumulator gpca_checker u_gpca_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);

// File: bench/testbench.sv
// Self-checking testbench for the gated pulse count accumulator.
// Drives sample words, predicts each result word and compares field by field.
// Depends on gpca_pkg and gated_pulse_count_accumulator.
`timescale 1ns / 1ps

module testbench;

	localparam int STALL_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_SHOWN     = 10;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_RANDOM,
		READY_RHYTHM,
		READY_BURSTY
	} ready_mode_t;

	logic                                 clk          = 1'b0;
	logic                                 arst_n       = 1'b0;
	logic                                 sample_valid = 1'b0;
	logic                                 sample_ready;
	gpca_pkg::sample_t                    sample       = '0;
	logic                                 result_valid;
	logic                                 result_ready = 1'b0;
	gpca_pkg::result_t                    result;
	logic                                 cfg_we       = 1'b0;
	logic [gpca_pkg::CFG_IDX_W-1:0]       cfg_index    = '0;
	logic [gpca_pkg::CFG_DATA_W-1:0]      cfg_wdata    = '0;

	// Predictor copy of the settings and the running state
	logic        pol_high          = gpca_pkg::RST_ACTIVE_HIGH;
	logic [23:0] debounce_setting  = '0;
	logic [14:0] threshold_setting = gpca_pkg::RST_FOLD_THRESHOLD;
	int          prev_count        = 0;
	logic [31:0] idle_start        = '0;
	logic        gate_open         = 1'b0;
	logic [31:0] accepted_sum      = '0;
	logic [31:0] raw_sum           = '0;
	logic [31:0] ignored_sum       = '0;
	logic [31:0] sample_sum        = '0;
	logic [31:0] fold_sum          = '0;
	logic [31:0] accept_stamp      = '0;

	gpca_pkg::result_t expected_totals[$];
	int          error_count  = 0;
	int          burst_left   = 0;
	int          gap_max      = 0;
	int          quiet_cycles = 0;
	int          ready_phase  = 0;
	ready_mode_t ready_mode   = READY_ALWAYS;

	gated_pulse_count_accumulator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	always #10 clk = ~clk;

	// Expected totals after one sample; advances the predictor state
	function automatic gpca_pkg::result_t count_sample(gpca_pkg::sample_t s);
		gpca_pkg::result_t r;
		int          hw;
		int          delta;
		int          thr;
		logic [31:0] win;
		logic        on_lvl;
		logic        fold_now;
		hw       = int'(s.hw_count);
		thr      = int'(threshold_setting);
		on_lvl   = pol_high ? s.pin_level : !s.pin_level;
		fold_now = (hw >= thr) || (hw <= -thr);
		delta    = hw - prev_count;
		win      = (debounce_setting == 0) ? 32'd0 :
			(32'(debounce_setting) + 32'd999) / 32'd1000;
		sample_sum++;
		// idle timer; a start stamp of zero reads as not idle
		if (!on_lvl) begin
			if (idle_start == 0) idle_start = s.now_ms;
			if (!gate_open && (win == 0 || (s.now_ms - idle_start) >= win)) gate_open = 1'b1;
		end else begin
			idle_start = '0;
		end
		// only a rising count produces pulses
		if (delta > 0) begin
			raw_sum += delta;
			if (win == 0) begin
				accepted_sum += delta;
				accept_stamp = s.now_ms;
			end else if (gate_open) begin
				accepted_sum++;
				accept_stamp = s.now_ms;
				gate_open    = 1'b0;
				idle_start   = '0;
				ignored_sum += delta - 1;
			end else begin
				ignored_sum += delta;
			end
		end
		prev_count = hw;
		if (fold_now) begin
			prev_count = 0;
			fold_sum++;
		end
		r.logical_on      = on_lvl;
		r.accepted_pulses = accepted_sum;
		r.raw_pulses      = raw_sum;
		r.ignored_pulses  = ignored_sum;
		r.samples_taken   = sample_sum;
		r.folds_done      = fold_sum;
		r.last_accept_ms  = accept_stamp;
		r.clear_request   = fold_now;
		return r;
	endfunction

	task automatic note_error(input string msg);
		error_count++;
		if (error_count <= MAX_SHOWN) $display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) note_error($sformatf("%s expected %h got %h", name, want, got));
	endtask

	// Track register writes and predict each accepted sample word
	always @(posedge clk) begin
		if (cfg_we) begin
			case (cfg_index)
				gpca_pkg::CFG_ACTIVE_HIGH:    pol_high = cfg_wdata[0];
				gpca_pkg::CFG_DEBOUNCE_US:
					debounce_setting = cfg_wdata[gpca_pkg::DEBOUNCE_W-1:0];
				gpca_pkg::CFG_FOLD_THRESHOLD:
					threshold_setting = cfg_wdata[gpca_pkg::FOLD_W-1:0];
				default: ;
			endcase
		end
		if (arst_n && sample_valid && sample_ready)
			expected_totals.push_back(count_sample(sample));
	end

	// Compare each result word against the oldest prediction
	always @(posedge clk) begin
		gpca_pkg::result_t want;
		if (arst_n && result_valid && result_ready) begin
			if (expected_totals.size() == 0) begin
				note_error($sformatf("result word with nothing expected: %h", result));
			end else begin
				want = expected_totals.pop_front();
				check_field("logical_on", 32'(want.logical_on), 32'(result.logical_on));
				check_field("accepted_pulses", want.accepted_pulses, result.accepted_pulses);
				check_field("raw_pulses", want.raw_pulses, result.raw_pulses);
				check_field("ignored_pulses", want.ignored_pulses, result.ignored_pulses);
				check_field("samples_taken", want.samples_taken, result.samples_taken);
				check_field("folds_done", want.folds_done, result.folds_done);
				check_field("last_accept_ms", want.last_accept_ms, result.last_accept_ms);
				check_field("clear_request", 32'(want.clear_request),
					32'(result.clear_request));
			end
		end
	end

	// Receiver back-pressure from a randomly chosen pattern
	always @(posedge clk) begin
		ready_phase++;
		if (ready_phase % 400 == 0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
		case (ready_mode)
			READY_ALWAYS: result_ready <= 1'b1;
			READY_RANDOM: result_ready <= ($urandom_range(0, 3) != 0);
			READY_RHYTHM: result_ready <= (ready_phase % 8) < 5;
			default:      result_ready <= (ready_phase % 32) < 20;
		endcase
	end

	// Watchdog: too long without any handshake ends the run
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready) || cfg_we)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	function automatic gpca_pkg::sample_t make_word(input logic [31:0] now, input int hw,
		input logic pin);
		gpca_pkg::sample_t w;
		w.now_ms    = now;
		w.hw_count  = gpca_pkg::HW_COUNT_WIDTH'(hw);
		w.pin_level = pin;
		return w;
	endfunction

	// Send one sample word; bursts with random gaps when gap_max is nonzero
	task automatic send_word(input gpca_pkg::sample_t w);
		if (gap_max > 0 && burst_left == 0) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, gap_max)) @(posedge clk);
			burst_left = $urandom_range(1, 12);
		end
		if (burst_left > 0) burst_left--;
		sample       <= w;
		sample_valid <= 1'b1;
		do @(posedge clk); while (!sample_ready);
	endtask

	// Hold the sender until every predicted word has come back
	task automatic drain_results();
		sample_valid <= 1'b0;
		do @(posedge clk); while (expected_totals.size() != 0);
	endtask

	task automatic set_register(input logic [gpca_pkg::CFG_IDX_W-1:0] idx,
		input int unsigned value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= gpca_pkg::CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic test_reset_behavior();
		send_word(make_word(32'd0, 0, 1'b0));            // idle starts at time zero
		send_word(make_word(32'd5, 3, 1'b1));
		send_word(make_word(32'd6, 3, 1'b1));            // count unchanged
		send_word(make_word(32'd7, 1, 1'b0));            // count went down
		send_word(make_word(32'hFFFF_FFFF, 32767, 1'b1)); // top of range folds
		send_word(make_word(32'd8, -32768, 1'b0));       // bottom of range folds
	endtask

	task automatic test_polarity();
		set_register(gpca_pkg::CFG_ACTIVE_HIGH, 0);
		send_word(make_word(32'd9, 2, 1'b0));
		send_word(make_word(32'd10, 2, 1'b1));
		set_register(gpca_pkg::CFG_ACTIVE_HIGH, 1);
	endtask

	task automatic test_debounce_gate();
		// one ms window: arm, take one pulse, drop the bounce
		set_register(gpca_pkg::CFG_DEBOUNCE_US, 1000);
		send_word(make_word(32'd100, 2, 1'b0));
		send_word(make_word(32'd101, 2, 1'b0));
		send_word(make_word(32'd102, 5, 1'b1));
		send_word(make_word(32'd103, 7, 1'b1));
		// longest window never arms here
		set_register(gpca_pkg::CFG_DEBOUNCE_US, 32'h00FF_FFFF);
		send_word(make_word(32'd200, 7, 1'b0));
		send_word(make_word(32'd201, 9, 1'b1));
		// idle stamp of zero does not count; the timer restarts next sample
		set_register(gpca_pkg::CFG_DEBOUNCE_US, 1);
		send_word(make_word(32'd0, 9, 1'b0));
		send_word(make_word(32'd1, 9, 1'b0));
		send_word(make_word(32'd2, 9, 1'b0));
		send_word(make_word(32'd3, 10, 1'b1));
	endtask

	task automatic test_fold_threshold();
		set_register(gpca_pkg::CFG_FOLD_THRESHOLD, 1);
		send_word(make_word(32'd300, 1, 1'b1));
		send_word(make_word(32'd301, -1, 1'b0));
		send_word(make_word(32'd302, 0, 1'b1));
		// zero threshold folds on every sample
		set_register(gpca_pkg::CFG_FOLD_THRESHOLD, 0);
		send_word(make_word(32'd303, 0, 1'b1));
		set_register(gpca_pkg::CFG_FOLD_THRESHOLD, 32767);
		send_word(make_word(32'd304, 32767, 1'b1));
		send_word(make_word(32'd305, -32767, 1'b0));
		send_word(make_word(32'd306, 32766, 1'b1));
	endtask

	// Realistic pin/counter traffic per settings phase, with some noise words
	task automatic test_random_traffic(input int phases, input int per_phase);
		logic [31:0]        clock_ms;
		logic signed [15:0] counter;
		logic               level_on;
		logic               pol;
		logic [23:0]        deb;
		int                 thr;
		int                 hv;
		int                 p;
		int                 i;
		gpca_pkg::sample_t  w;
		clock_ms = 32'd5000;
		counter  = '0;
		level_on = 1'b0;
		for (p = 0; p < phases; p++) begin
			pol = 1'($urandom_range(0, 1));
			case ($urandom_range(0, 6))
				0:       deb = '0;
				1:       deb = 24'd1;
				2:       deb = 24'd1000;
				3:       deb = 24'd1001;
				4:       deb = '1;
				default: deb = 24'($urandom_range(1, 6000));
			endcase
			case ($urandom_range(0, 7))
				0:       thr = 0;
				1:       thr = 1;
				2:       thr = 32767;
				3:       thr = 16384;
				default: thr = $urandom_range(2, 60);
			endcase
			set_register(gpca_pkg::CFG_ACTIVE_HIGH, 32'(pol));
			set_register(gpca_pkg::CFG_DEBOUNCE_US, 32'(deb));
			set_register(gpca_pkg::CFG_FOLD_THRESHOLD, thr);
			gap_max = (p % 3 == 0) ? 0 : $urandom_range(1, 6);
			// sometimes run the timestamp across its wrap
			if ($urandom_range(0, 3) == 0) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 300);
			for (i = 0; i < per_phase; i++) begin
				if (i == per_phase / 2) drain_results();
				if ($urandom_range(0, 9) == 0) begin
					// noise word: arbitrary time, count and level
					w = make_word($urandom, int'($urandom), 1'($urandom_range(0, 1)));
					if ($urandom_range(0, 1)) counter = w.hw_count;
				end else begin
					clock_ms += $urandom_range(0, 3);
					if ($urandom_range(0, 2) == 0) begin
						level_on = !level_on;
						// rising edge: one count plus occasional contact bounce
						if (level_on)
							counter += 16'(1 + (($urandom_range(0, 3) == 0) ?
								$urandom_range(1, 3) : 0));
					end else if (level_on && $urandom_range(0, 7) == 0) begin
						counter += 16'sd1;
					end else if ($urandom_range(0, 19) == 0) begin
						counter -= 16'($urandom_range(1, 2));
					end
					w = make_word(clock_ms, int'(counter), pol ? level_on : !level_on);
				end
				// a fold clears the hardware counter
				hv = int'(w.hw_count);
				if (hv >= thr || hv <= -thr) counter = '0;
				send_word(w);
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		gap_max = 2;
		test_reset_behavior();
		test_polarity();
		test_debounce_gate();
		test_fold_threshold();
		test_random_traffic(8, 240);
		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		error_count += expected_totals.size();
		if (error_count == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
